>>> src/sqrr_pkg.sv
// ----------------------------------------------------------------------------
// sqrr_pkg
// Shared constants, command struct and element helpers for the square tile
// rotate / reflect block.
// ----------------------------------------------------------------------------
package sqrr_pkg;

  localparam int MAX_DIM        = 8;
  localparam int ELEM_WIDTH     = 16;
  localparam int DEFAULT_STRIDE = 5;
  localparam int RESET_SIZE     = 5;

  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W = 2 * DIM_W;
  localparam int DEPTH  = 1 << ADDR_W;

  // command codes
  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_ROTATE  = 2'd1;
  localparam logic [1:0] MODE_REFLECT = 2'd2;

  localparam logic [1:0] CHOICE_NONE  = 2'd0;
  localparam logic [1:0] ROT_90       = 2'd1;
  localparam logic [1:0] ROT_180      = 2'd2;
  localparam logic [1:0] ROT_270      = 2'd3;
  localparam logic [1:0] REFL_X       = 2'd1;
  localparam logic [1:0] REFL_Y       = 2'd2;
  localparam logic [1:0] REFL_POINT   = 2'd3;

  // controller -> datapath command
  typedef struct packed {
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ELEM_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic                  rd_primary;
    logic                  rd_rotate;
    logic [ADDR_W-1:0]     rd_addr;
    logic [DIM_W-1:0]      row;
    logic [DIM_W-1:0]      col;
    logic                  last;
  } cmd_t;

  // 16-bit signed input -> stored element
  function automatic logic [ELEM_WIDTH-1:0] to_elem(input logic [15:0] v);
    logic [31:0] ext;
    ext = 32'(signed'(v));
    return ext[ELEM_WIDTH-1:0];
  endfunction

  // stored element -> 16-bit output
  function automatic logic [15:0] to_out(input logic [ELEM_WIDTH-1:0] e);
    logic [31:0] ext;
    ext = 32'(signed'(e));
    return ext[15:0];
  endfunction

  // reset tile: r*5 + c + 1
  function automatic logic [ELEM_WIDTH-1:0] default_elem(input logic [ADDR_W-1:0] a);
    logic [31:0] r;
    logic [31:0] c;
    logic [31:0] s;
    r = 32'(a[ADDR_W-1:DIM_W]);
    c = 32'(a[DIM_W-1:0]);
    s = r * 32'(DEFAULT_STRIDE) + c + 32'd1;
    return s[ELEM_WIDTH-1:0];
  endfunction

endpackage

>>> src/sqrr_ctrl.sv
// ----------------------------------------------------------------------------
// sqrr_ctrl
// Command sequencer: size register, row/column scan and source address map.
// ----------------------------------------------------------------------------
module sqrr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            mode_i,
  input  logic [2:0]            elem_row_i,
  input  logic [2:0]            elem_col_i,
  input  logic signed [15:0]    elem_value_i,
  input  logic [1:0]            choice_i,
  input  logic                  source_select_i,
  input  logic                  cfg_we_i,
  input  logic [3:0]            cfg_data_i,
  output sqrr_pkg::cmd_t        cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN
  } state_e;

  state_e                      state_q;
  logic [sqrr_pkg::DIM_W-1:0]  i_q, j_q;
  logic                        rotate_q;
  logic [1:0]                  choice_q;
  logic                        src_q;
  logic [3:0]                  size_q;

  logic                        accept;
  logic [3:0]                  n;
  logic [sqrr_pkg::DIM_W-1:0]  nm1, ri, rj, src_r, src_c;
  logic                        row_ok, col_ok, last;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // clamp size to 1..MAX_DIM
  always_comb begin
    priority if (size_q == 4'd0) begin
      n = 4'd1;
    end else if (size_q > 4'(sqrr_pkg::MAX_DIM)) begin
      n = 4'(sqrr_pkg::MAX_DIM);
    end else begin
      n = size_q;
    end
  end

  assign nm1    = sqrr_pkg::DIM_W'(n - 4'd1);
  assign ri     = nm1 - i_q;
  assign rj     = nm1 - j_q;
  assign row_ok = ({1'b0, elem_row_i} < n);
  assign col_ok = ({1'b0, elem_col_i} < n);
  assign last   = (i_q == nm1) && (j_q == nm1);

  always_comb begin
    src_r = i_q;
    src_c = j_q;
    if (rotate_q) begin
      unique case (choice_q)
        sqrr_pkg::ROT_90:  begin src_r = j_q; src_c = ri;  end
        sqrr_pkg::ROT_180: begin src_r = ri;  src_c = rj;  end
        sqrr_pkg::ROT_270: begin src_r = rj;  src_c = i_q; end
        default:           begin src_r = i_q; src_c = j_q; end
      endcase
    end else begin
      unique case (choice_q)
        sqrr_pkg::REFL_X:     begin src_r = ri;  src_c = j_q; end
        sqrr_pkg::REFL_Y:     begin src_r = i_q; src_c = rj;  end
        sqrr_pkg::REFL_POINT: begin src_r = ri;  src_c = rj;  end
        default:              begin src_r = i_q; src_c = j_q; end
      endcase
    end
  end

  always_comb begin
    cmd_o.wr_en      = accept && (mode_i == sqrr_pkg::MODE_WRITE) && row_ok && col_ok;
    cmd_o.wr_addr    = {elem_row_i[sqrr_pkg::DIM_W-1:0], elem_col_i[sqrr_pkg::DIM_W-1:0]};
    cmd_o.wr_data    = sqrr_pkg::to_elem(elem_value_i);
    cmd_o.rd_en      = (state_q == S_ISSUE);
    cmd_o.rd_primary = rotate_q || src_q;
    cmd_o.rd_rotate  = rotate_q;
    cmd_o.rd_addr    = {src_r, src_c};
    cmd_o.row        = i_q;
    cmd_o.col        = j_q;
    cmd_o.last       = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      rotate_q <= 1'b0;
      choice_q <= sqrr_pkg::CHOICE_NONE;
      src_q    <= 1'b0;
      size_q   <= 4'(sqrr_pkg::RESET_SIZE);
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && (mode_i == sqrr_pkg::MODE_ROTATE || mode_i == sqrr_pkg::MODE_REFLECT)
              && choice_i != sqrr_pkg::CHOICE_NONE) begin
            state_q  <= S_ISSUE;
            i_q      <= '0;
            j_q      <= '0;
            rotate_q <= (mode_i == sqrr_pkg::MODE_ROTATE);
            choice_q <= choice_i;
            src_q    <= source_select_i;
          end
        end
        S_ISSUE: begin
          if (last) begin
            state_q <= S_DRAIN;
          end else if (j_q == nm1) begin
            j_q <= '0;
            i_q <= i_q + 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_DRAIN: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // a write transfer never occupies the sequencer
  a_write_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i == sqrr_pkg::MODE_WRITE) |=> !busy)
    else $error("write left controller busy");

  // a valid rotate starts its scan at the origin
  a_rotate_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i == sqrr_pkg::MODE_ROTATE && choice_i != sqrr_pkg::CHOICE_NONE)
    |=> (cmd_o.rd_en && cmd_o.row == '0 && cmd_o.col == '0))
    else $error("rotate scan did not start at origin");

  // the scan issues without gaps until its last element
  a_issue_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_en && !cmd_o.last) |=> cmd_o.rd_en)
    else $error("gap in element scan");

endmodule

>>> src/sqrr_datapath.sv
// ----------------------------------------------------------------------------
// sqrr_datapath
// Primary and rotated tile memories with reset-default valid bits and the
// registered result stage.
// ----------------------------------------------------------------------------
module sqrr_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sqrr_pkg::cmd_t        cmd_i,
  output logic                  out_strobe_o,
  output logic signed [15:0]    out_value_o,
  output logic [2:0]            out_row_o,
  output logic [2:0]            out_col_o,
  output logic                  last_element_o
);

  logic [sqrr_pkg::ELEM_WIDTH-1:0] prim_mem [sqrr_pkg::DEPTH];
  logic [sqrr_pkg::ELEM_WIDTH-1:0] rot_mem  [sqrr_pkg::DEPTH];

  logic [sqrr_pkg::DEPTH-1:0]      prim_vld_q, rot_vld_q;
  logic                            prim_hit_q, rot_hit_q;
  logic [sqrr_pkg::ELEM_WIDTH-1:0] prim_rd_q, rot_rd_q, def_q;

  logic                            strobe_q, wb_q, last_q, sel_prim_q;
  logic [sqrr_pkg::DIM_W-1:0]      row_q, col_q;
  logic [sqrr_pkg::ELEM_WIDTH-1:0] elem;

  // entries never written read as the reset tile
  always_comb begin
    if (sel_prim_q) begin
      elem = prim_hit_q ? prim_rd_q : def_q;
    end else begin
      elem = rot_hit_q ? rot_rd_q : def_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      prim_mem[cmd_i.wr_addr] <= cmd_i.wr_data;
    end
    if (cmd_i.rd_en) begin
      prim_rd_q <= prim_mem[cmd_i.rd_addr];
      def_q     <= sqrr_pkg::default_elem(cmd_i.rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_q) begin
      rot_mem[{row_q, col_q}] <= elem;
    end
    if (cmd_i.rd_en) begin
      rot_rd_q <= rot_mem[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      row_q      <= cmd_i.row;
      col_q      <= cmd_i.col;
      sel_prim_q <= cmd_i.rd_primary;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prim_vld_q <= '0;
      rot_vld_q  <= '0;
      prim_hit_q <= 1'b0;
      rot_hit_q  <= 1'b0;
      strobe_q   <= 1'b0;
      wb_q       <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        prim_vld_q[cmd_i.wr_addr] <= 1'b1;
      end
      if (wb_q) begin
        rot_vld_q[{row_q, col_q}] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        prim_hit_q <= prim_vld_q[cmd_i.rd_addr];
        rot_hit_q  <= rot_vld_q[cmd_i.rd_addr];
      end
      strobe_q <= cmd_i.rd_en;
      wb_q     <= cmd_i.rd_en && cmd_i.rd_rotate;
      last_q   <= cmd_i.rd_en && cmd_i.last;
    end
  end

  assign out_strobe_o   = strobe_q;
  assign out_value_o    = sqrr_pkg::to_out(elem);
  assign out_row_o      = 3'(row_q);
  assign out_col_o      = 3'(col_q);
  assign last_element_o = strobe_q && last_q;

  a_strobe_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(cmd_i.rd_en))
    else $error("result without a preceding read");

  a_tile_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !last_element_o) |=> out_strobe_o)
    else $error("tile output ended without last element");

  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd_en && cmd_i.last) |=> last_element_o)
    else $error("final element not marked last");

endmodule

>>> src/square_matrix_rotate_reflect.sv
// ----------------------------------------------------------------------------
// square_matrix_rotate_reflect
// Write: busy stays low. Rotate/reflect: results follow the start transfer
// through the state register and the registered memory read, one element per
// cycle from the memory read port, and busy stays high through the scan and
// drain states. The receiver cannot stall; results stream.
// Reset (async, active low) returns size to 5 and both tiles to r*5+c+1.
// ----------------------------------------------------------------------------
module square_matrix_rotate_reflect (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command channel: a transfer happens when start is high and busy low
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode_i,
  input  logic [2:0]          elem_row_i,
  input  logic [2:0]          elem_col_i,
  input  logic signed [15:0]  elem_value_i,
  input  logic [1:0]          choice_i,
  input  logic                source_select_i,
  // size register write
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_data_i,
  // result channel: one element per strobe, row-major
  output logic                out_strobe_o,
  output logic signed [15:0]  out_value_o,
  output logic [2:0]          out_row_o,
  output logic [2:0]          out_col_o,
  output logic                last_element_o
);

  // Controller owns the size register and the scan counters. It turns each
  // output position (i,j) into the source address for the selected turn or
  // mirror and hands a read command to the datapath every cycle of the scan.
  sqrr_pkg::cmd_t cmd;

  sqrr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .elem_row_i      (elem_row_i),
    .elem_col_i      (elem_col_i),
    .elem_value_i    (elem_value_i),
    .choice_i        (choice_i),
    .source_select_i (source_select_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_o           (cmd)
  );

  // Datapath holds both tiles. Reads are registered; on a rotate the element
  // read from the primary tile is written into the rotated tile in the same
  // cycle it is presented on the result ports. Valid bits let never-written
  // entries read back as the reset tile with no clearing sweep.
  sqrr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .out_strobe_o   (out_strobe_o),
    .out_value_o    (out_value_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .last_element_o (last_element_o)
  );

endmodule
